// File: src/pdrl_pkg.sv
// Shared types, constants and codes for the packet dedup and rate limit filter.
package pdrl_pkg;

    // Duplicate history
    localparam int HISTORY_DEPTH = 20;

    // Front-to-back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Application ports
    localparam logic [8:0] PORT_TEXT       = 9'd1;
    localparam logic [8:0] PORT_POSITION   = 9'd3;
    localparam logic [8:0] PORT_WAYPOINT   = 9'd8;
    localparam logic [8:0] PORT_ALERT      = 9'd11;
    localparam logic [8:0] PORT_TELEMETRY  = 9'd67;
    localparam logic [8:0] PORT_TRACEROUTE = 9'd70;

    localparam logic [31:0] BROADCAST_NODE = 32'hFFFF_FFFF;

    // Send-time slots
    localparam int NUM_SLOTS = 6;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam logic [SLOT_W-1:0] SLOT_TEXT       = SLOT_W'(0);
    localparam logic [SLOT_W-1:0] SLOT_POSITION   = SLOT_W'(1);
    localparam logic [SLOT_W-1:0] SLOT_WAYPOINT   = SLOT_W'(2);
    localparam logic [SLOT_W-1:0] SLOT_ALERT      = SLOT_W'(3);
    localparam logic [SLOT_W-1:0] SLOT_TELEMETRY  = SLOT_W'(4);
    localparam logic [SLOT_W-1:0] SLOT_TRACEROUTE = SLOT_W'(5);

    // Rate class of a packet
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_NONE  = 2'd0;
    localparam kind_t KIND_TEXT  = 2'd1;
    localparam kind_t KIND_POS   = 2'd2;
    localparam kind_t KIND_TRACE = 2'd3;

    // Verdict codes
    typedef logic [2:0] verdict_t;
    localparam verdict_t VERDICT_ACCEPT     = 3'd0;
    localparam verdict_t VERDICT_DUPLICATE  = 3'd1;
    localparam verdict_t VERDICT_TRACE_RATE = 3'd2;
    localparam verdict_t VERDICT_TRACE_BCST = 3'd3;
    localparam verdict_t VERDICT_POS_RATE   = 3'd4;
    localparam verdict_t VERDICT_TEXT_RATE  = 3'd5;

    // Configuration registers
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACE_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_WINDOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_WINDOW  = 2'd2;

    localparam logic [31:0] TRACE_WINDOW_RST = 32'd30000;
    localparam logic [31:0] POS_WINDOW_RST   = 32'd10000;
    localparam logic [31:0] TEXT_WINDOW_RST  = 32'd2000;

    // Stream widths
    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 8;

    // Classified item handed from front to back
    typedef struct packed {
        logic [31:0]       packet_id;
        logic [31:0]       now_ms;
        logic [SLOT_W-1:0] slot;
        logic              slot_vld;
        kind_t             kind;
        logic              bcast;
        logic              multi_hop;
    } item_t;

endpackage

// File: src/pdrl_front.sv
// Input side: takes packet transfers, decodes port class and slot, pushes to the queue.
module pdrl_front (
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pdrl_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic                            q_full,
    output logic                            q_push,
    output pdrl_pkg::item_t                 q_item
);
    import pdrl_pkg::*;

    logic [31:0] packet_id;
    logic [8:0]  port_num;
    logic [31:0] dest_node;
    logic [2:0]  hop_cnt;
    logic [31:0] now_ms;

    assign packet_id = s_tdata[31:0];
    assign port_num  = s_tdata[40:32];
    assign dest_node = s_tdata[72:41];
    assign hop_cnt   = s_tdata[75:73];
    assign now_ms    = s_tdata[107:76];

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_item           = '0;
        q_item.packet_id = packet_id;
        q_item.now_ms    = now_ms;
        q_item.bcast     = (dest_node == BROADCAST_NODE);
        q_item.multi_hop = (hop_cnt != 3'd0);
        unique case (port_num)
            PORT_TEXT: begin
                q_item.slot = SLOT_TEXT;  q_item.slot_vld = 1'b1; q_item.kind = KIND_TEXT;
            end
            PORT_POSITION: begin
                q_item.slot = SLOT_POSITION; q_item.slot_vld = 1'b1; q_item.kind = KIND_POS;
            end
            PORT_WAYPOINT: begin
                q_item.slot = SLOT_WAYPOINT; q_item.slot_vld = 1'b1; q_item.kind = KIND_POS;
            end
            PORT_ALERT: begin
                q_item.slot = SLOT_ALERT; q_item.slot_vld = 1'b1; q_item.kind = KIND_POS;
            end
            PORT_TELEMETRY: begin
                q_item.slot = SLOT_TELEMETRY; q_item.slot_vld = 1'b1; q_item.kind = KIND_POS;
            end
            PORT_TRACEROUTE: begin
                q_item.slot = SLOT_TRACEROUTE; q_item.slot_vld = 1'b1;
                q_item.kind = KIND_TRACE;
            end
            default: begin
                q_item.slot = '0; q_item.slot_vld = 1'b0; q_item.kind = KIND_NONE;
            end
        endcase
    end

endmodule

// File: src/pdrl_queue.sv
// Short register queue between the front and back parts.
module pdrl_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  pdrl_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output pdrl_pkg::item_t head_item,
    output logic            empty
);
    import pdrl_pkg::*;

    item_t                  entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push, do_pop;

    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: src/pdrl_back.sv
// Back part: history compare, rate checks, state update and result register.
module pdrl_back (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  q_empty,
    input  pdrl_pkg::item_t                       q_head,
    output logic                                  q_pop,
    input  logic                                  cfg_valid,
    input  logic [pdrl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [31:0]                           cfg_data,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [pdrl_pkg::OUT_TDATA_W-1:0]      m_tdata
);
    import pdrl_pkg::*;

    localparam logic ST_IDLE    = 1'b0;
    localparam logic ST_RESOLVE = 1'b1;

    logic state_reg, state_next;

    // Stored state
    logic [31:0] hist_reg  [HISTORY_DEPTH];
    logic [31:0] hist_next [HISTORY_DEPTH];
    logic [31:0] times_reg [NUM_SLOTS];
    logic [31:0] trace_win_reg, pos_win_reg, text_win_reg;

    // Stage registers
    item_t                    item_reg;
    logic [HISTORY_DEPTH-1:0] hit_vec_reg, empty_vec_reg;
    logic                     soon_reg;

    // Output register
    logic     m_tvalid_reg;
    verdict_t verdict_reg;
    logic     ack_reg;

    // Stage 1 logic
    logic [HISTORY_DEPTH-1:0] hit_vec, empty_vec;
    logic [31:0]              last_time, window, elapsed;
    logic                     soon;

    // Stage 2 logic
    logic [HISTORY_DEPTH-1:0] cand_vec, first_oh;
    logic                     id_nz, dup, store_slot, do_shift;
    logic                     out_free, commit;
    verdict_t                 verdict;
    logic                     ack;

    assign out_free = !m_tvalid_reg || m_tready;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign commit   = (state_reg == ST_RESOLVE) && out_free;

    // Compare against every history entry at once
    always_comb begin
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hit_vec[i]   = (hist_reg[i] == q_head.packet_id);
            empty_vec[i] = (hist_reg[i] == '0);
        end
    end

    always_comb begin
        last_time = q_head.slot_vld ? times_reg[q_head.slot] : '0;
        unique case (q_head.kind)
            KIND_TRACE: window = trace_win_reg;
            KIND_POS:   window = pos_win_reg;
            KIND_TEXT:  window = text_win_reg;
            default:    window = '0;
        endcase
        elapsed = q_head.now_ms - last_time;
        soon    = q_head.slot_vld && (last_time != '0) && (elapsed < window);
    end

    // First slot that matches or is empty, as in a scan from index 0
    assign cand_vec   = hit_vec_reg | empty_vec_reg;
    assign first_oh   = cand_vec & ~(cand_vec - 1'b1);
    assign id_nz      = (item_reg.packet_id != '0);
    assign dup        = id_nz && ((first_oh & hit_vec_reg) != '0);
    assign store_slot = id_nz && !dup && ((first_oh & empty_vec_reg) != '0);
    assign do_shift   = id_nz && !dup && (first_oh == '0);

    always_comb begin
        priority if (dup) begin
            verdict = VERDICT_DUPLICATE;
        end else if (item_reg.kind == KIND_TRACE && soon_reg) begin
            verdict = VERDICT_TRACE_RATE;
        end else if (item_reg.kind == KIND_TRACE && item_reg.bcast && item_reg.multi_hop) begin
            verdict = VERDICT_TRACE_BCST;
        end else if (item_reg.kind == KIND_POS && soon_reg) begin
            verdict = VERDICT_POS_RATE;
        end else if (item_reg.kind == KIND_TEXT && soon_reg) begin
            verdict = VERDICT_TEXT_RATE;
        end else begin
            verdict = VERDICT_ACCEPT;
        end
        ack = (verdict == VERDICT_ACCEPT) && (item_reg.kind == KIND_TRACE) && !item_reg.bcast;
    end

    always_comb begin
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_next[i] = hist_reg[i];
        end
        if (commit && store_slot) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                if (first_oh[i]) begin
                    hist_next[i] = item_reg.packet_id;
                end
            end
        end else if (commit && do_shift) begin
            for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
                hist_next[i] = hist_reg[i + 1];
            end
            hist_next[HISTORY_DEPTH - 1] = item_reg.packet_id;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (!q_empty) state_next = ST_RESOLVE;
            ST_RESOLVE: if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_tvalid_reg  <= 1'b0;
            trace_win_reg <= TRACE_WINDOW_RST;
            pos_win_reg   <= POS_WINDOW_RST;
            text_win_reg  <= TEXT_WINDOW_RST;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                hist_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_SLOTS; i++) begin
                times_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                hist_reg[i] <= hist_next[i];
            end
            if (commit) begin
                m_tvalid_reg <= 1'b1;
                if (verdict == VERDICT_ACCEPT && item_reg.slot_vld) begin
                    times_reg[item_reg.slot] <= item_reg.now_ms;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_TRACE_WINDOW: trace_win_reg <= cfg_data;
                    CFG_POS_WINDOW:   pos_win_reg   <= cfg_data;
                    CFG_TEXT_WINDOW:  text_win_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            item_reg      <= q_head;
            hit_vec_reg   <= hit_vec;
            empty_vec_reg <= empty_vec;
            soon_reg      <= soon;
        end
        if (commit) begin
            verdict_reg <= verdict;
            ack_reg     <= ack;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - 4){1'b0}}, ack_reg, verdict_reg};

`ifndef NO_ASSERTIONS
    a_pop_starts_resolve: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (state_reg == ST_RESOLVE))
        else $error("pop did not start resolve");

    a_stall_holds_resolve: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESOLVE && !out_free) |=> (state_reg == ST_RESOLVE))
        else $error("resolve left while result port blocked");

    a_ack_only_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (!ack_reg || verdict_reg == VERDICT_ACCEPT))
        else $error("want-ack on rejected packet");

    a_commit_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> m_tvalid_reg)
        else $error("committed result not presented");
`endif

endmodule

// File: src/packet_dedup_rate_limit_filter_unit.sv
// Top level of the packet duplicate suppression and rate limit filter.
//
// Each packet transfer on s_ yields exactly one verdict transfer on m_, in order.
// The front decodes the port into a rate class and send-time slot and pushes the
// packet into a two-entry queue, so the input keeps taking packets while a verdict
// waits on the m_ side. The back takes one packet at a time; its idle state
// compares the id against all HISTORY_DEPTH history entries in parallel and
// checks the slot's elapsed time (wrap-aware 32-bit subtract) against its window;
// the resolve state resolves the first matching or empty history slot, picks the
// verdict by priority (duplicate, traceroute rate, broadcast multi-hop
// traceroute, position-class rate, text rate), updates history and send time,
// and loads the output register, holding while m_ is blocked. A zero id skips
// the history; ids are recorded even for rate-limited packets. A send time of
// zero reads as never sent. The user writes window registers (cfg_index 0
// traceroute, 1 position class, 2 text; other indexes ignored) only while no
// packet is in flight; the block does not enforce this. cfg_ready is always
// high. History and send times clear at reset with no clearing pass.
module packet_dedup_rate_limit_filter_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // packet input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [31:0] packet_id, [40:32] port_num, [72:41] dest_node,
    // [75:73] hop count, [107:76] now_ms, [111:108] zero
    input  logic [pdrl_pkg::IN_TDATA_W-1:0]  s_tdata,
    // verdict output
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [2:0] verdict, [3] forced ack request, [7:4] zero
    output logic [pdrl_pkg::OUT_TDATA_W-1:0] m_tdata,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pdrl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                      cfg_data
);
    import pdrl_pkg::*;

    item_t push_item, head_item;
    logic  q_push, q_full, q_pop, q_empty;

    // Window registers take a write every cycle
    assign cfg_ready = 1'b1;

    pdrl_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    pdrl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .head_item (head_item),
        .empty     (q_empty)
    );

    pdrl_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_head    (head_item),
        .q_pop     (q_pop),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// File: tb/sv/pdrl_scoreboard_pkg.sv
// Verdict scoreboard for the packet dedup and rate limit filter testbench.
package pdrl_scoreboard_pkg;

    import pdrl_pkg::*;

    localparam int NO_SLOT = -1;

    typedef struct packed {
        verdict_t verdict;
        logic     ack_req;
    } verdict_item_t;

    class admission_scoreboard;

        logic [31:0]   recent_ids [HISTORY_DEPTH];
        logic [31:0]   sent_at    [NUM_SLOTS];
        logic [31:0]   trace_window;
        logic [31:0]   pos_window;
        logic [31:0]   text_window;
        verdict_item_t expected_verdicts [$];
        int            mismatches;
        int            verdicts_seen;

        function new();
            foreach (recent_ids[i]) recent_ids[i] = '0;
            foreach (sent_at[i]) sent_at[i] = '0;
            trace_window  = TRACE_WINDOW_RST;
            pos_window    = POS_WINDOW_RST;
            text_window   = TEXT_WINDOW_RST;
            mismatches    = 0;
            verdicts_seen = 0;
        endfunction

        // One line per mismatch; printing stops after a screenful, counting goes on.
        task report_mismatch(input string msg);
            if (mismatches < 40)
                $display("ERROR %0t ns: %s", $time, msg);
            mismatches++;
        endtask

        function void set_window(input logic [CFG_IDX_W-1:0] index, input logic [31:0] value);
            case (index)
                CFG_TRACE_WINDOW: trace_window = value;
                CFG_POS_WINDOW:   pos_window   = value;
                CFG_TEXT_WINDOW:  text_window  = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_verdicts.size();
        endfunction

        // Stored time of zero means never sent; elapsed time is mod 2^32.
        function bit held_off(input int slot, input logic [31:0] now,
                              input logic [31:0] window);
            logic [31:0] elapsed;
            if (slot == NO_SLOT || sent_at[slot] == '0)
                return 1'b0;
            elapsed = now - sent_at[slot];
            return elapsed < window;
        endfunction

        // Predict the verdict for one accepted packet and update history/send times.
        function void note_packet(input logic [IN_TDATA_W-1:0] tdata);
            logic [31:0]   id;
            logic [31:0]   dest;
            logic [31:0]   now;
            logic [8:0]    port;
            logic [2:0]    hops;
            int            slot;
            int            i;
            bit            bcast;
            bit            trace;
            bit            pos_class;
            bit            hit;
            bit            placed;
            verdict_item_t e;

            id   = tdata[31:0];
            port = tdata[40:32];
            dest = tdata[72:41];
            hops = tdata[75:73];
            now  = tdata[107:76];

            case (port)
                PORT_TEXT:       slot = int'(SLOT_TEXT);
                PORT_POSITION:   slot = int'(SLOT_POSITION);
                PORT_WAYPOINT:   slot = int'(SLOT_WAYPOINT);
                PORT_ALERT:      slot = int'(SLOT_ALERT);
                PORT_TELEMETRY:  slot = int'(SLOT_TELEMETRY);
                PORT_TRACEROUTE: slot = int'(SLOT_TRACEROUTE);
                default:         slot = NO_SLOT;
            endcase
            bcast     = (dest == BROADCAST_NODE);
            trace     = (port == PORT_TRACEROUTE);
            pos_class = (port == PORT_POSITION) || (port == PORT_WAYPOINT) ||
                        (port == PORT_ALERT) || (port == PORT_TELEMETRY);

            // history: hit, else first empty slot, else shift and append
            hit    = 1'b0;
            placed = 1'b0;
            if (id != '0) begin
                for (i = 0; i < HISTORY_DEPTH && !hit && !placed; i++) begin
                    if (recent_ids[i] == id) begin
                        hit = 1'b1;
                    end else if (recent_ids[i] == '0) begin
                        recent_ids[i] = id;
                        placed = 1'b1;
                    end
                end
                if (!hit && !placed) begin
                    for (i = 0; i < HISTORY_DEPTH - 1; i++)
                        recent_ids[i] = recent_ids[i + 1];
                    recent_ids[HISTORY_DEPTH - 1] = id;
                end
            end

            e.ack_req = 1'b0;
            if (hit) begin
                e.verdict = VERDICT_DUPLICATE;
            end else if (trace && held_off(slot, now, trace_window)) begin
                e.verdict = VERDICT_TRACE_RATE;
            end else if (trace && bcast && hops != '0) begin
                e.verdict = VERDICT_TRACE_BCST;
            end else if (pos_class && held_off(slot, now, pos_window)) begin
                e.verdict = VERDICT_POS_RATE;
            end else if (port == PORT_TEXT && held_off(slot, now, text_window)) begin
                e.verdict = VERDICT_TEXT_RATE;
            end else begin
                e.verdict = VERDICT_ACCEPT;
                e.ack_req = trace && !bcast;
                if (slot != NO_SLOT)
                    sent_at[slot] = now;
            end
            expected_verdicts.insert(expected_verdicts.size(), e);
        endfunction

        task check_verdict(input logic [OUT_TDATA_W-1:0] tdata);
            verdict_item_t e;
            if (expected_verdicts.size() == 0) begin
                report_mismatch($sformatf("verdict %0d ack %0d with no packet outstanding",
                                          tdata[2:0], tdata[3]));
                return;
            end
            e = expected_verdicts[0];
            expected_verdicts.delete(0);
            if (tdata[2:0] !== e.verdict)
                report_mismatch($sformatf("verdict #%0d: got %0d, want %0d",
                                          verdicts_seen, tdata[2:0], e.verdict));
            if (tdata[3] !== e.ack_req)
                report_mismatch($sformatf("verdict #%0d: ack request got %0b, want %0b",
                                          verdicts_seen, tdata[3], e.ack_req));
            verdicts_seen++;
        endtask

        task finish_check();
            if (expected_verdicts.size() != 0)
                report_mismatch($sformatf("%0d verdicts never arrived",
                                          expected_verdicts.size()));
        endtask

    endclass

endpackage

// File: tb/sv/packet_dedup_rate_limit_filter_unit_tb.sv
// Self-checking testbench for the packet dedup and rate limit filter.
module packet_dedup_rate_limit_filter_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pdrl_pkg::*;
    import pdrl_scoreboard_pkg::*;

    localparam int CLK_HALF = 5;
    // Generous ceiling; a correct run with full stalls needs well under 1 ms.
    localparam int RUN_LIMIT_NS = 5_000_000;
    // Index outside the register map; the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_TRACE_WINDOW;
    logic [31:0]            cfg_data  = '0;

    admission_scoreboard sb = new();

    // Sender burst shaping and receiver stall pattern state
    int          burst_left    = 4;
    bit          sender_steady = 1'b0;   // 1: no gaps between packets
    int          hold_left     = 0;
    bit          receiver_free = 1'b0;   // 1: m_tready stays high

    // Millisecond clock seen by the well-formed traffic, and ids handed out lately
    logic [31:0] clock_ms = 32'd5000;
    logic [31:0] used_ids [$];

    packet_dedup_rate_limit_filter_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF aclk = ~aclk;

    // Receiver: holds m_tready at one level for a random stretch, then picks again.
    // Mostly ready: two picks in three set m_tready high.
    always @(negedge aclk) begin
        if (hold_left == 0) begin
            hold_left <= $urandom_range(0, 11);
            m_tready  <= receiver_free || ($urandom_range(0, 2) != 0);
        end else begin
            hold_left <= hold_left - 1;
        end
    end

    // Transfer monitors, sampled on the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_packet(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_verdict(m_tdata);
        end
    end

    // Present one packet from a falling edge, hold until the transfer, then
    // possibly end the burst with a random gap. Returns on a falling edge.
    task automatic send_packet(input logic [31:0] id, input logic [8:0] port,
                               input logic [31:0] dest, input logic [2:0] hops,
                               input logic [31:0] now);
        s_tdata  <= {4'b0000, now, hops, dest, port, id};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        if (!sender_steady) begin
            burst_left--;
            if (burst_left <= 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge aclk);
                burst_left = $urandom_range(1, 8);
            end
        end
    endtask

    // Stop sending and wait for every outstanding verdict.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // cfg_valid is left high so back-to-back writes never drop it in between.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [31:0] value);
        cfg_index <= index;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_window(index, value);
        @(negedge aclk);
    endtask

    task automatic set_windows(input logic [31:0] trace_ms, input logic [31:0] pos_ms,
                               input logic [31:0] text_ms);
        write_reg(CFG_TRACE_WINDOW, trace_ms);
        write_reg(CFG_POS_WINDOW, pos_ms);
        write_reg(CFG_TEXT_WINDOW, text_ms);
        cfg_valid <= 1'b0;
    endtask

    // Mostly plausible traffic: rising time, the six rate-limited ports, ids that
    // sometimes repeat within the history depth. About one in twelve is raw noise.
    task automatic send_random(input int count);
        logic [31:0] id;
        logic [31:0] dest;
        logic [8:0]  port;
        logic [2:0]  hops;
        int          r;
        repeat (count) begin
            if ($urandom_range(0, 99) < 8) begin
                send_packet($urandom, 9'($urandom), $urandom, 3'($urandom), $urandom);
            end else begin
                case ($urandom_range(0, 3))
                    0:       clock_ms += $urandom_range(0, 50);
                    1:       clock_ms += $urandom_range(0, 3000);
                    2:       clock_ms += $urandom_range(0, 12000);
                    default: clock_ms += $urandom_range(0, 40000);
                endcase
                case ($urandom_range(0, 7))
                    0:       port = PORT_TEXT;
                    1:       port = PORT_POSITION;
                    2:       port = PORT_WAYPOINT;
                    3:       port = PORT_ALERT;
                    4:       port = PORT_TELEMETRY;
                    5, 6:    port = PORT_TRACEROUTE;
                    default: port = 9'($urandom);
                endcase
                case ($urandom_range(0, 9))
                    0, 1, 2: dest = BROADCAST_NODE;
                    3:       dest = $urandom_range(0, 15);
                    default: dest = $urandom;
                endcase
                hops = 3'($urandom);
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    id = '0;
                end else if (r < 35 && used_ids.size() != 0) begin
                    id = used_ids[$urandom_range(0, used_ids.size() - 1)];
                end else begin
                    id = $urandom;
                    used_ids.insert(used_ids.size(), id);
                    // a little deeper than the history, so repeats both hit and miss
                    if (used_ids.size() > HISTORY_DEPTH + 8)
                        used_ids.delete(0);
                end
                send_packet(id, port, dest, hops, clock_ms);
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // ---- Directed, reset windows (30000 / 10000 / 2000) ----
        // zero id skips the history: same zero id twice is not a duplicate
        send_packet(32'd0, 9'd511, 32'd0, 3'd0, 32'd0);
        send_packet(32'd0, 9'd511, 32'd0, 3'd0, 32'd0);
        // all-ones fields on an unlisted port, then the same id again
        send_packet(32'hFFFF_FFFF, 9'd0, BROADCAST_NODE, 3'd7, 32'hFFFF_FFFF);
        send_packet(32'hFFFF_FFFF, 9'd0, BROADCAST_NODE, 3'd7, 32'hFFFF_FFFF);
        // unicast traceroute accepted with ack, then too soon
        send_packet(32'd1, PORT_TRACEROUTE, 32'd5, 3'd3, 32'd1000);
        send_packet(32'd2, PORT_TRACEROUTE, 32'd5, 3'd3, 32'd1500);
        // broadcast traceroute: multi-hop refused, zero-hop accepted without ack
        send_packet(32'd3, PORT_TRACEROUTE, BROADCAST_NODE, 3'd2, 32'd40000);
        send_packet(32'd4, PORT_TRACEROUTE, BROADCAST_NODE, 3'd0, 32'd40001);
        // traceroute rate outranks the broadcast multi-hop refusal
        send_packet(32'd5, PORT_TRACEROUTE, BROADCAST_NODE, 3'd7, 32'd41000);
        // position class, each port keeps its own time
        send_packet(32'd6, PORT_POSITION, 32'd9, 3'd1, 32'd100);
        send_packet(32'd7, PORT_POSITION, 32'd9, 3'd1, 32'd200);
        send_packet(32'd8, PORT_WAYPOINT, 32'd9, 3'd1, 32'd300);
        send_packet(32'd9, PORT_WAYPOINT, 32'd9, 3'd1, 32'd10299);
        send_packet(32'd10, PORT_WAYPOINT, 32'd9, 3'd1, 32'd10300);
        send_packet(32'd11, PORT_ALERT, 32'd9, 3'd1, 32'd5);
        send_packet(32'd12, PORT_ALERT, 32'd9, 3'd1, 32'd6);
        send_packet(32'd13, PORT_TELEMETRY, 32'd9, 3'd1, 32'd7);
        send_packet(32'd14, PORT_TELEMETRY, 32'd9, 3'd1, 32'd8);
        // text sent at time zero still reads as never sent
        send_packet(32'd15, PORT_TEXT, 32'd9, 3'd0, 32'd0);
        send_packet(32'd16, PORT_TEXT, 32'd9, 3'd0, 32'd1);
        send_packet(32'd17, PORT_TEXT, 32'd9, 3'd0, 32'd2);
        // elapsed time across the 32-bit wrap
        send_packet(32'd18, PORT_TEXT, 32'd9, 3'd0, 32'hFFFF_FF00);
        send_packet(32'd19, PORT_TEXT, 32'd9, 3'd0, 32'h0000_0100);
        // repeat of an id that was rate limited earlier still counts as seen
        send_packet(32'd12, PORT_TEXT, 32'd9, 3'd0, 32'h0010_0000);

        // ---- Random traffic under several window settings ----
        send_random(200);
        wait_drained();

        // zero windows never limit
        set_windows(32'd0, 32'd0, 32'd0);
        send_random(150);
        wait_drained();

        // maximum windows; the unmapped index must leave them alone
        write_reg(CFG_TRACE_WINDOW, 32'hFFFF_FFFF);
        write_reg(CFG_POS_WINDOW, 32'hFFFF_FFFF);
        write_reg(CFG_TEXT_WINDOW, 32'hFFFF_FFFF);
        write_reg(CFG_UNMAPPED, 32'd1);
        cfg_valid <= 1'b0;
        send_random(150);
        wait_drained();

        // random windows, clock running through the wrap; pause midway until drained
        set_windows($urandom_range(0, 40000), $urandom_range(0, 15000),
                    $urandom_range(0, 4000));
        clock_ms = 32'hFFFF_C000;
        send_random(120);
        wait_drained();
        send_random(130);
        wait_drained();

        // back to reset values, receiver never stalls
        set_windows(TRACE_WINDOW_RST, POS_WINDOW_RST, TEXT_WINDOW_RST);
        receiver_free = 1'b1;
        send_random(250);
        wait_drained();

        // tight windows, sender never idles, receiver stalls again
        set_windows($urandom_range(0, 200), $urandom_range(0, 200), $urandom_range(0, 200));
        receiver_free = 1'b0;
        sender_steady = 1'b1;
        send_random(100);
        wait_drained();

        // let any stray verdict show up before the verdict is decided
        repeat (20) @(posedge aclk);
        sb.finish_check();
        if (sb.mismatches == 0)
            $display("** packet_dedup_rate_limit_filter_unit: PASSED **");
        else
            $display("** packet_dedup_rate_limit_filter_unit: FAILED **");
        $finish;
    end

    // Hang guard
    initial begin
        #(RUN_LIMIT_NS);
        $display("TIMEOUT: %0d verdicts outstanding", sb.pending());
        $display("** packet_dedup_rate_limit_filter_unit: FAILED **");
        $finish;
    end

endmodule

// File: files.f
src/pdrl_pkg.sv
src/pdrl_front.sv
src/pdrl_queue.sv
src/pdrl_back.sv
src/packet_dedup_rate_limit_filter_unit.sv
tb/sv/pdrl_scoreboard_pkg.sv
tb/sv/packet_dedup_rate_limit_filter_unit_tb.sv
